// ----- hdl/ata_pkg.sv -----
// Package for the animation track advance unit.
// Holds widths, register and finish codes, the side-band struct and the keyframe helper.
// No dependencies.
`timescale 1ns / 1ps
package ata_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IDX_BITS  = 16;
  localparam int TIME_BITS = 2 * FRAC_BITS;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int RATE_W    = FRAC_BITS + 8;
  localparam int CFG_W     = RATE_W;
  localparam int CFG_IDX_W = 3;
  localparam int QUO_BITS  = FRAC_BITS + 2;
  localparam int NUM_W     = TIME_BITS + QUO_BITS;
  localparam int DEN_W     = TIME_BITS + 1;
  localparam int BLEND_W   = FRAC_BITS + 4;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam logic signed [BLEND_W-1:0] ONE_S = BLEND_W'(ONE);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANIM_START,
    REG_ANIM_END,
    REG_FRAME_RATE,
    REG_PLAY_SPEED,
    REG_LOOP_ENABLE,
    REG_ANIM_PRESENT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FIN_DIRECT,
    FIN_MOD,
    FIN_NEGMOD,
    FIN_BLEND
  } fin_mode_t;

  typedef struct packed {
    fin_mode_t                   mode;
    logic [TIME_BITS-1:0]        frame;
    logic [DEN_W-1:0]            bound;
    logic signed [BLEND_W-1:0]   beg;
    logic                        dneg;
    logic [IDX_BITS-1:0]         pre;
    logic [IDX_BITS-1:0]         post;
    logic [IDX_BITS-1:0]         a;
    logic [IDX_BITS-1:0]         b;
    logic [TIME_BITS-1:0]        trans;
  } ata_side_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]  a;
    logic [IDX_BITS-1:0]  b;
    logic [FRAC_BITS-1:0] f;
  } ata_keys_t;

  function automatic ata_keys_t derive_keys(input logic [TIME_BITS-1:0] frame,
                                            input logic [IDX_BITS-1:0] start,
                                            input logic [IDX_BITS-1:0] eff_end,
                                            input logic present);
    ata_keys_t k;
    logic [IDX_BITS:0] sa;
    logic [IDX_BITS:0] sb;
    sa = {1'b0, start} + (IDX_BITS+1)'(frame[TIME_BITS-1:FRAC_BITS]);
    sb = sa + (IDX_BITS+1)'(|frame[FRAC_BITS-1:0]);
    k.a = (sa > {1'b0, eff_end}) ? start : sa[IDX_BITS-1:0];
    k.b = (sb > {1'b0, eff_end}) ? start : sb[IDX_BITS-1:0];
    k.f = frame[FRAC_BITS-1:0];
    if (!present) begin
      k = '0;
    end
    return k;
  endfunction

endpackage

// ----- hdl/ata_if.sv -----
// Request channels of the animation track advance unit: input track and result track.
// Depends on ata_pkg.
`timescale 1ns / 1ps
interface ata_in_if;
  import ata_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] time_step;
  logic [TIME_BITS-1:0] frame_in;
  logic [TIME_BITS-1:0] trans_in;
  logic [IDX_BITS-1:0]  index_a_in;
  logic [IDX_BITS-1:0]  index_b_in;
  logic [FRAC_W-1:0]    frac_in;
  modport source (output valid, time_step, frame_in, trans_in, index_a_in, index_b_in,
                  frac_in, input ready);
  modport sink (input valid, time_step, frame_in, trans_in, index_a_in, index_b_in,
                frac_in, output ready);
endinterface

interface ata_out_if;
  import ata_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] frame_out;
  logic [TIME_BITS-1:0] trans_out;
  logic [IDX_BITS-1:0]  index_a_out;
  logic [IDX_BITS-1:0]  index_b_out;
  logic [FRAC_W-1:0]    frac_out;
  modport source (output valid, frame_out, trans_out, index_a_out, index_b_out, frac_out,
                  input ready);
  modport sink (input valid, frame_out, trans_out, index_a_out, index_b_out, frac_out,
                output ready);
endinterface

// ----- hdl/ata_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side-band payload.
// Depends on ata_pkg.
`timescale 1ns / 1ps
module ata_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [ata_pkg::NUM_W-1:0] num,
  input  logic [ata_pkg::DEN_W-1:0] den,
  input  ata_pkg::ata_side_t        side,
  output logic                      out_valid,
  output logic [ata_pkg::QUO_BITS-1:0] quo,
  output logic [ata_pkg::DEN_W-1:0] rmd,
  output ata_pkg::ata_side_t        side_out
);
  import ata_pkg::*;

  logic [QUO_BITS:0]    vld;
  logic [NUM_W-1:0]     r     [QUO_BITS+1];
  logic [QUO_BITS-1:0]  q     [QUO_BITS+1];
  logic [DEN_W-1:0]     dv    [QUO_BITS+1];
  ata_side_t            sd    [QUO_BITS+1];

  assign vld[0] = in_valid;
  assign r[0]   = num;
  assign q[0]   = '0;
  assign dv[0]  = den;
  assign sd[0]  = side;

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    localparam int SH = QUO_BITS - 1 - k;
    logic [NUM_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {1'b0, r[k]} - (((NUM_W+1)'(dv[k])) << SH);
      ge    = !trial[NUM_W];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1]  <= ge ? trial[NUM_W-1:0] : r[k];
        q[k+1]  <= {q[k][QUO_BITS-2:0], ge};
        dv[k+1] <= dv[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[QUO_BITS];
  assign quo       = q[QUO_BITS];
  assign rmd       = r[QUO_BITS][DEN_W-1:0];
  assign side_out  = sd[QUO_BITS];

endmodule

// ----- hdl/animation_track_advance_unit.sv -----
// Animation track advance unit: one track request in, one updated track out.
// Throughput: one request per cycle while the output is not stalled; the 18-stage divider sets the depth.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, rst high) clears all valid bits and loads register defaults.
// Depends on ata_pkg, ata_if and ata_div.
`timescale 1ns / 1ps
module animation_track_advance_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ata_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ata_pkg::CFG_W-1:0]     cfg_data,
  ata_in_if.sink                        in_req,
  ata_out_if.source                     out_req
);
  import ata_pkg::*;

  logic [IDX_BITS-1:0]       anim_start;
  logic [IDX_BITS-1:0]       anim_end;
  logic [RATE_W-1:0]         frame_rate;
  logic signed [RATE_W-1:0]  play_speed;
  logic                      loop_enable;
  logic                      anim_present;

  logic [IDX_BITS-1:0]       eff_end;
  logic [IDX_BITS-1:0]       len;
  logic [TIME_BITS-1:0]      rate_prod;
  logic [RATE_W-1:0]         speed_mag;
  logic [2*RATE_W-1:0]       rate_full;
  logic                      fwd;

  logic                      en;
  logic                      out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      anim_start   <= '0;
      anim_end     <= '0;
      frame_rate   <= '0;
      play_speed   <= RATE_W'(ONE);
      loop_enable  <= 1'b0;
      anim_present <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ANIM_START:   anim_start   <= cfg_data[IDX_BITS-1:0];
        REG_ANIM_END:     anim_end     <= cfg_data[IDX_BITS-1:0];
        REG_FRAME_RATE:   frame_rate   <= cfg_data[RATE_W-1:0];
        REG_PLAY_SPEED:   play_speed   <= cfg_data[RATE_W-1:0];
        REG_LOOP_ENABLE:  loop_enable  <= cfg_data[0];
        REG_ANIM_PRESENT: anim_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign fwd       = !play_speed[RATE_W-1];
  assign speed_mag = play_speed[RATE_W-1] ? RATE_W'(-play_speed) : play_speed;
  assign rate_full = frame_rate * speed_mag;

  always_ff @(posedge clk) begin
    eff_end   <= (anim_end < anim_start) ? anim_start : anim_end;
    len       <= ((anim_end < anim_start) ? anim_start : anim_end) - anim_start;
    rate_prod <= rate_full[FRAC_BITS +: TIME_BITS];
  end

  assign en           = !out_valid || out_req.ready;
  assign in_req.ready = en && !rst;

  // Stage 0: capture request
  logic                 s0_valid;
  logic [TIME_BITS-1:0] s0_tstep, s0_frame, s0_trans;
  logic [IDX_BITS-1:0]  s0_a, s0_b;
  logic [FRAC_W-1:0]    s0_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_tstep <= in_req.time_step;
      s0_frame <= in_req.frame_in;
      s0_trans <= in_req.trans_in;
      s0_a     <= in_req.index_a_in;
      s0_b     <= in_req.index_b_in;
      s0_f     <= in_req.frac_in;
    end
  end

  // Stage 1: path select, keyframes around the frame, blend span
  ata_keys_t                 k1;
  logic                      tp1;
  logic signed [BLEND_W-1:0] f_s, endp0, beg1, endp1, d1, dabs1;
  logic                      m1, m2;

  always_comb begin
    tp1   = s0_trans <= s0_tstep;
    k1    = derive_keys(s0_frame, anim_start, eff_end, anim_present);
    f_s   = $signed(BLEND_W'(s0_f));
    endp0 = $signed(BLEND_W'(k1.f));
    m1    = (s0_a == k1.a) && (s0_b == k1.b);
    m2    = (s0_a == k1.b) && (s0_b == k1.a);
    if (m1) begin
      beg1  = f_s + ONE_S;
      endp1 = endp0;
    end else if (m2) begin
      beg1  = f_s + ONE_S;
      endp1 = ONE_S - endp0;
    end else begin
      beg1  = (s0_b == k1.a || s0_b == k1.b || s0_f == '0) ? f_s : f_s - ONE_S;
      endp1 = (!fwd && k1.a != k1.b) ? ONE_S - endp0 : endp0;
    end
    d1    = endp1 + ONE_S - beg1;
    dabs1 = d1[BLEND_W-1] ? -d1 : d1;
  end

  logic                      s1_valid, s1_tp, s1_dneg;
  logic [TIME_BITS-1:0]      s1_rem, s1_tstep, s1_trans, s1_frame;
  logic [QUO_BITS-1:0]       s1_dmag;
  logic signed [BLEND_W-1:0] s1_beg;
  logic [IDX_BITS-1:0]       s1_pre, s1_post, s1_a, s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tp    <= tp1;
      s1_rem   <= s0_tstep - s0_trans;
      s1_dmag  <= dabs1[QUO_BITS-1:0];
      s1_dneg  <= d1[BLEND_W-1];
      s1_beg   <= beg1;
      s1_pre   <= k1.a;
      s1_post  <= k1.b;
      s1_a     <= s0_a;
      s1_b     <= s0_b;
      s1_tstep <= s0_tstep;
      s1_trans <= s0_trans;
      s1_frame <= s0_frame;
    end
  end

  // Stage 2: shared multiplier, advance product or blend numerator
  logic [TIME_BITS-1:0]      mul_a, mul_b;
  logic                      s2_valid, s2_tp, s2_dneg;
  logic [2*TIME_BITS-1:0]    s2_prod;
  logic [TIME_BITS-1:0]      s2_tstep, s2_trans, s2_frame;
  logic signed [BLEND_W-1:0] s2_beg;
  logic [IDX_BITS-1:0]       s2_pre, s2_post, s2_a, s2_b;

  assign mul_a = s1_tp ? rate_prod : TIME_BITS'(s1_dmag);
  assign mul_b = s1_tp ? s1_rem : s1_tstep;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod  <= mul_a * mul_b;
      s2_tp    <= s1_tp;
      s2_dneg  <= s1_dneg;
      s2_beg   <= s1_beg;
      s2_pre   <= s1_pre;
      s2_post  <= s1_post;
      s2_a     <= s1_a;
      s2_b     <= s1_b;
      s2_tstep <= s1_tstep;
      s2_trans <= s1_trans;
      s2_frame <= s1_frame;
    end
  end

  // Stage 3: saturate advance, wrap or clamp setup, divider operands
  logic [2*TIME_BITS-FRAC_BITS-1:0] adv_full;
  logic [TIME_BITS-1:0]             adv, lim;
  logic [TIME_BITS:0]               sum_f;
  logic [DEN_W-1:0]                 bound;
  logic                             neg;
  ata_side_t                        side3;
  logic [NUM_W-1:0]                 num3;
  logic [DEN_W-1:0]                 den3;

  always_comb begin
    adv_full = s2_prod[2*TIME_BITS-1:FRAC_BITS];
    adv      = (|adv_full[2*TIME_BITS-FRAC_BITS-1:TIME_BITS]) ? '1
                                                             : adv_full[TIME_BITS-1:0];
    neg      = play_speed[RATE_W-1] && (adv != '0);
    sum_f    = {1'b0, s2_frame} + {1'b0, adv};
    bound    = {(IDX_BITS+1)'({1'b0, len} + (IDX_BITS+1)'(1)), {FRAC_BITS{1'b0}}};
    lim      = {len, {FRAC_BITS{1'b0}}};
    side3.mode  = FIN_DIRECT;
    side3.frame = s2_frame;
    side3.bound = bound;
    side3.beg   = s2_beg;
    side3.dneg  = s2_dneg;
    side3.pre   = s2_pre;
    side3.post  = s2_post;
    side3.a     = s2_a;
    side3.b     = s2_b;
    side3.trans = '0;
    num3 = '0;
    den3 = bound;
    if (s2_tp) begin
      if (anim_present) begin
        if (!neg) begin
          if (loop_enable) begin
            side3.mode = FIN_MOD;
            num3       = NUM_W'(sum_f);
          end else begin
            side3.frame = (sum_f > {1'b0, lim}) ? lim : sum_f[TIME_BITS-1:0];
          end
        end else if (s2_frame >= adv) begin
          side3.frame = s2_frame - adv;
        end else if (loop_enable) begin
          side3.mode = FIN_NEGMOD;
          num3       = NUM_W'(adv - s2_frame);
        end else begin
          side3.frame = '0;
        end
      end
    end else begin
      side3.mode  = FIN_BLEND;
      side3.trans = s2_trans - s2_tstep;
      num3        = s2_prod[NUM_W-1:0];
      den3        = {1'b0, s2_trans};
    end
  end

  logic             s3_valid;
  ata_side_t        s3_side;
  logic [NUM_W-1:0] s3_num;
  logic [DEN_W-1:0] s3_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= side3;
      s3_num  <= num3;
      s3_den  <= den3;
    end
  end

  logic                div_valid;
  logic [QUO_BITS-1:0] div_quo;
  logic [DEN_W-1:0]    div_rmd;
  ata_side_t           div_side;

  ata_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_valid),
    .num      (s3_num),
    .den      (s3_den),
    .side     (s3_side),
    .out_valid(div_valid),
    .quo      (div_quo),
    .rmd      (div_rmd),
    .side_out (div_side)
  );

  // Finish: frame wrap result or blend step
  logic [TIME_BITS-1:0]      fr;
  ata_keys_t                 kf;
  logic signed [BLEND_W-1:0] t, fs;
  logic [IDX_BITS-1:0]       a_n, b_n;
  logic [FRAC_W-1:0]         f_n;

  always_comb begin
    case (div_side.mode)
      FIN_MOD:    fr = div_rmd[TIME_BITS-1:0];
      FIN_NEGMOD: fr = (div_rmd == '0) ? '0 : TIME_BITS'(div_side.bound - div_rmd);
      default:    fr = div_side.frame;
    endcase
    kf  = derive_keys(fr, anim_start, eff_end, anim_present);
    t   = div_side.dneg ? div_side.beg - $signed(BLEND_W'(div_quo))
                        : div_side.beg + $signed(BLEND_W'(div_quo));
    a_n = div_side.a;
    b_n = div_side.b;
    fs  = t;
    if (div_side.mode != FIN_BLEND) begin
      a_n = kf.a;
      b_n = kf.b;
      fs  = $signed(BLEND_W'(kf.f));
    end else if (t < 0) begin
      fs = t + ONE_S;
    end else if (t <= ONE_S) begin
      if (div_side.b != div_side.pre && div_side.b != div_side.post) begin
        a_n = div_side.b;
        b_n = fwd ? div_side.pre : div_side.post;
      end
    end else begin
      if (div_side.b == div_side.pre) begin
        if (div_side.a != div_side.post) begin
          a_n = div_side.pre;
          b_n = div_side.post;
        end
      end else if (div_side.b == div_side.post) begin
        if (div_side.a != div_side.pre) begin
          a_n = div_side.post;
          b_n = div_side.pre;
        end
      end else if (fwd) begin
        a_n = div_side.pre;
        b_n = div_side.post;
      end else begin
        a_n = div_side.post;
        b_n = div_side.pre;
      end
      fs = t - ONE_S;
    end
    f_n = (fs < 0) ? '0 : fs[FRAC_W-1:0];
  end

  logic [TIME_BITS-1:0] frame_q, trans_q;
  logic [IDX_BITS-1:0]  a_q, b_q;
  logic [FRAC_W-1:0]    f_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame_q <= fr;
      trans_q <= div_side.trans;
      a_q     <= a_n;
      b_q     <= b_n;
      f_q     <= f_n;
    end
  end

  assign out_req.valid       = out_valid;
  assign out_req.frame_out   = frame_q;
  assign out_req.trans_out   = trans_q;
  assign out_req.index_a_out = a_q;
  assign out_req.index_b_out = b_q;
  assign out_req.frac_out    = f_q;

endmodule

// ----- hdl/ata_chk.sv -----
// Port checker for the animation track advance unit, attached by bind.
// Depends on animation_track_advance_unit and its request channels.
`timescale 1ns / 1ps
module ata_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] frame_out
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result request valid after reset");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input not ready with empty output");

  a_ready_drain: assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input not ready while output drains");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_out))
    else $error("stalled result request dropped or changed");

endmodule

bind animation_track_advance_unit ata_chk u_ata_chk (
  .clk      (clk),
  .rst      (rst),
  .in_ready (in_req.ready),
  .out_valid(out_req.valid),
  .out_ready(out_req.ready),
  .frame_out(out_req.frame_out)
);
